### hw/rtl/tlf_pkg.sv
// ----------------------------------------------------------------------------
// tlf_pkg: shared types and constants for the text line folder
// Character codes, parameter defaults, sequencer states and the control
// bundle that the sequencer drives into the datapath.
// ----------------------------------------------------------------------------
package tlf_pkg;

  // parameter defaults
  localparam int unsigned LINE_WIDTH_DEF = 32;
  localparam int unsigned TAB_WIDTH_DEF  = 8;

  // character codes
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_BLANK = 8'd32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TAB,
    ST_EMIT
  } tlf_state_e;

  // per-cycle control from the sequencer
  typedef struct packed {
    logic ram_we;     // write one character into the line store
    logic ram_re;     // issue one line store read
    logic load_char;  // move read data into the output register
    logic load_nl;    // load the closing newline into the output register
  } tlf_ctl_t;

endpackage

### hw/rtl/tlf_ram.sv
// ----------------------------------------------------------------------------
// tlf_ram: generic single-write, single-read memory
// One write port and one read port; read data is registered and holds
// while no read is issued.
// ----------------------------------------------------------------------------
module tlf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/tlf_seq.sv
// ----------------------------------------------------------------------------
// tlf_seq: line folder sequencer
// Keeps the circular line buffer pointers, the tab column and the last
// blank position; steps tab expansion, and run emission while the output is free, one slot a cycle.
// ----------------------------------------------------------------------------
module tlf_seq #(
  parameter int unsigned LINE_WIDTH = tlf_pkg::LINE_WIDTH_DEF,
  parameter int unsigned TAB_WIDTH  = tlf_pkg::TAB_WIDTH_DEF,
  localparam int unsigned AW = $clog2(LINE_WIDTH)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [7:0]        char_in_i,
  input  logic              out_free_i,
  output logic              in_stall_o,
  output tlf_pkg::tlf_ctl_t ctl_o,
  output logic [AW-1:0]     waddr_o,
  output logic [7:0]        wdata_o,
  output logic [AW-1:0]     raddr_o
);

  localparam int unsigned FW = $clog2(LINE_WIDTH + 1);
  localparam int unsigned SW = FW + 1;
  localparam int unsigned CW = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;

  tlf_pkg::tlf_state_e state_q, state_d;
  logic [AW-1:0] head_q, head_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [FW-1:0] lastb_q, lastb_d;
  logic [CW-1:0] col_q, col_d;
  logic [FW-1:0] run_len_q, run_len_d;
  logic [FW-1:0] rd_idx_q, rd_idx_d;
  logic          rd_pend_q, rd_pend_d;

  logic          accept, is_nl, is_tab, is_blank;
  logic [FW-1:0] fill_inc, lastb_chr, run_len_chr;
  logic          hit_full, tab_done;
  logic [CW-1:0] col_inc, col_dec;
  logic          run_left, move, issue, nl_go;

  // circular index: a + b stays below twice the buffer size
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [FW-1:0] b);
    logic [SW-1:0] s;
    s = SW'(a) + SW'(b);
    if (s >= SW'(LINE_WIDTH)) begin
      s = s - SW'(LINE_WIDTH);
    end
    return s[AW-1:0];
  endfunction

  assign accept   = (state_q == tlf_pkg::ST_IDLE) && in_valid_i;
  assign is_nl    = (char_in_i == tlf_pkg::CH_NL);
  assign is_tab   = (char_in_i == tlf_pkg::CH_TAB);
  assign is_blank = (char_in_i == tlf_pkg::CH_BLANK);

  assign fill_inc    = fill_q + 1'b1;
  assign hit_full    = (fill_inc == FW'(LINE_WIDTH));
  assign col_inc     = (col_q == CW'(TAB_WIDTH - 1)) ? '0 : col_q + 1'b1;
  assign col_dec     = (col_q == '0) ? CW'(TAB_WIDTH - 1) : col_q - 1'b1;
  assign tab_done    = hit_full || (col_inc == '0);
  assign lastb_chr   = is_blank ? fill_inc : lastb_q;
  // fold cut: after the last blank, or the whole buffer when there is none
  assign run_len_chr = (lastb_chr == '0) ? FW'(LINE_WIDTH) : lastb_chr;

  assign run_left = (rd_idx_q != run_len_q);
  assign move     = rd_pend_q && out_free_i;
  assign issue    = (state_q == tlf_pkg::ST_EMIT) && run_left && (!rd_pend_q || move);
  assign nl_go    = (state_q == tlf_pkg::ST_EMIT) && !run_left && !rd_pend_q && out_free_i;

  assign waddr_o = wrap_add(head_q, fill_q);
  assign raddr_o = wrap_add(head_q, rd_idx_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tlf_pkg::ST_IDLE: begin
        if (accept) begin
          if (is_nl || (!is_tab && hit_full)) begin
            state_d = tlf_pkg::ST_EMIT;
          end else if (is_tab) begin
            state_d = tlf_pkg::ST_TAB;
          end
        end
      end
      tlf_pkg::ST_TAB: begin
        if (tab_done) begin
          state_d = hit_full ? tlf_pkg::ST_EMIT : tlf_pkg::ST_IDLE;
        end
      end
      tlf_pkg::ST_EMIT: begin
        if (nl_go) begin
          state_d = tlf_pkg::ST_IDLE;
        end
      end
      default: state_d = tlf_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall_o      = 1'b1;
    ctl_o           = '0;
    wdata_o         = tlf_pkg::CH_BLANK;
    case (state_q)
      tlf_pkg::ST_IDLE: begin
        in_stall_o   = 1'b0;
        ctl_o.ram_we = accept && !is_nl && !is_tab;
        wdata_o      = char_in_i;
      end
      tlf_pkg::ST_TAB: begin
        ctl_o.ram_we = 1'b1;
      end
      tlf_pkg::ST_EMIT: begin
        ctl_o.ram_re    = issue;
        ctl_o.load_char = move;
        ctl_o.load_nl   = nl_go;
      end
      default: in_stall_o = 1'b1;
    endcase
  end

  // buffer bookkeeping
  always_comb begin
    head_d    = head_q;
    fill_d    = fill_q;
    lastb_d   = lastb_q;
    col_d     = col_q;
    run_len_d = run_len_q;
    rd_idx_d  = rd_idx_q;
    rd_pend_d = rd_pend_q;
    case (state_q)
      tlf_pkg::ST_IDLE: begin
        rd_idx_d  = '0;
        rd_pend_d = 1'b0;
        if (accept) begin
          if (is_nl) begin
            run_len_d = fill_q;
          end else if (!is_tab) begin
            fill_d    = fill_inc;
            col_d     = col_inc;
            lastb_d   = lastb_chr;
            run_len_d = run_len_chr;
          end
        end
      end
      tlf_pkg::ST_TAB: begin
        fill_d    = fill_inc;
        col_d     = col_inc;
        lastb_d   = fill_inc;
        run_len_d = fill_inc;
      end
      tlf_pkg::ST_EMIT: begin
        rd_pend_d = issue || (rd_pend_q && !move);
        if (issue) begin
          rd_idx_d = rd_idx_q + 1'b1;
          col_d    = col_dec;
        end
        if (nl_go) begin
          head_d  = wrap_add(head_q, run_len_q);
          fill_d  = fill_q - run_len_q;
          lastb_d = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tlf_pkg::ST_IDLE;
      head_q    <= '0;
      fill_q    <= '0;
      lastb_q   <= '0;
      col_q     <= '0;
      run_len_q <= '0;
      rd_idx_q  <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      fill_q    <= fill_d;
      lastb_q   <= lastb_d;
      col_q     <= col_d;
      run_len_q <= run_len_d;
      rd_idx_q  <= rd_idx_d;
      rd_pend_q <= rd_pend_d;
    end
  end

endmodule

### hw/rtl/text_line_folder.sv
// ----------------------------------------------------------------------------
// text_line_folder: folds a character stream into lines of bounded width
// Buffers one line in a circular store, expands tabs and emits a line
// segment and a newline on each newline character or full buffer.
// ----------------------------------------------------------------------------
// usage
//   input channel: one character per transaction on char_in_i, taken at an
//   edge with in_valid_i high and in_stall_o low
//   output channel: char_out_o with last_of_run_o, taken at an edge with
//   out_valid_o high and out_stall_i low; last_of_run_o marks the newline
//   an ordinary character is written into the line store and produces nothing
//   unless it fills the buffer
//   a tab writes one blank per cycle up to the next tab stop (1 to
//   TAB_WIDTH blanks), clipped at the buffer end
//   a newline or a full buffer emits a run of n characters plus a newline;
//   input is held until the newline is loaded, one character per cycle while
//   the receiver does not stall, through the single read port of the line store
//   the output register decouples the sides: a receiver stall only pauses
//   the run, the held transaction stays put and nothing is lost
//   reset empties the buffer; no clearing pass, the store is only read
//   below the fill level; a partial line at end of input stays buffered
// ----------------------------------------------------------------------------
module text_line_folder #(
  parameter int unsigned LINE_WIDTH = tlf_pkg::LINE_WIDTH_DEF,
  parameter int unsigned TAB_WIDTH  = tlf_pkg::TAB_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_in_i,
  // output channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] char_out_o,
  output logic       last_of_run_o
);

  localparam int unsigned AW = $clog2(LINE_WIDTH);

  tlf_pkg::tlf_ctl_t ctl;
  logic [AW-1:0]     waddr, raddr;
  logic [7:0]        wdata, rdata;
  logic              out_free;

  logic       out_valid_q;
  logic [7:0] out_char_q;
  logic       out_last_q;

  // output register can take a new character this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  // sequencer: tab expansion, fold cut and run emission
  tlf_seq #(
    .LINE_WIDTH (LINE_WIDTH),
    .TAB_WIDTH  (TAB_WIDTH)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .char_in_i  (char_in_i),
    .out_free_i (out_free),
    .in_stall_o (in_stall_o),
    .ctl_o      (ctl),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .raddr_o    (raddr)
  );

  // circular line store, one slot per column
  tlf_ram #(
    .WIDTH (8),
    .DEPTH (LINE_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ctl.ram_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (ctl.ram_re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.load_char || ctl.load_nl) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload, loaded only when the register is free
  always_ff @(posedge clk_i) begin
    if (ctl.load_char) begin
      out_char_q <= rdata;
      out_last_q <= 1'b0;
    end else if (ctl.load_nl) begin
      out_char_q <= tlf_pkg::CH_NL;
      out_last_q <= 1'b1;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign char_out_o    = out_char_q;
  assign last_of_run_o = out_last_q;

`ifndef SYNTHESIS
  // a held transaction is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !(ctl.load_char || ctl.load_nl))
    else $error("output register overwritten while stalled");

  // a run closes with a newline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.load_nl |=> (out_valid_o && last_of_run_o && (char_out_o == tlf_pkg::CH_NL)))
    else $error("run end without closing newline");

  // buffer fill and run emission never overlap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl.ram_we && (ctl.ram_re || ctl.load_char || ctl.load_nl)))
    else $error("line store written during emission");

  // input is held while a run is emitted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.load_char || ctl.load_nl) |-> in_stall_o)
    else $error("input taken during emission");
`endif

endmodule
